// ===== src/osm_pkg.sv =====
// Shared types, constants and codes for the order statistic multiset.
// No dependencies; imported by every module of the block.
package osm_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int RANK_W   = 7;
  localparam int OUT_CNT_W = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;

  localparam logic [ACT_W-1:0] ACT_SELECT        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_COUNT_LESS    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_COUNT_AT_MOST = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INSERT        = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ERASE         = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_RANK = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 2'd3;

  typedef struct packed {
    logic lt;
    logic le;
    logic eq;
    logic hit;
  } cell_flags_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_upd_t;

endpackage

// ===== src/order_statistic_multiset_core.sv =====
// Top level of the order statistic multiset: request channel, result channel,
// the row of osm_cell storage cells and the osm_reduce flag reduction.
//
// Usage:
//   Requests arrive on s_tvalid / s_tready / s_tdata; each request yields
//   exactly one result on m_tvalid / m_tready / m_tdata.
//   Request fields: action, key, rank. Result fields: selected_key,
//   key_count, status.
//   On acceptance every cell compares its key with the request and registers
//   its flags; then the flags are reduced, the result register is loaded and
//   the chain shifts on insert or erase.
//   Each request must finish this compare-then-update pass before the next
//   one enters, since it sees the chain the previous one left behind.
//   Reset empties the store (fill zero) and drops any pending result; no
//   clearing pass is needed, as entries at or above the fill never reach a result.
//   When the receiver stalls, the result is held in the output register and
//   no further request is taken until it has been delivered.
module order_statistic_multiset_core
  import osm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // action[2:0], key[34:3], rank[41:35], zero fill
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // selected_key[31:0], key_count[38:32],
                                      // status[40:39], zero fill
);

  logic                       busy;
  logic [ACT_W-1:0]           req_action;
  logic signed [KEY_W-1:0]    req_key;
  logic [RANK_W-1:0]          req_rank;
  logic [CNT_W-1:0]           fill;
  logic [CNT_W-1:0]           fill_next;
  logic                       accept;

  logic [CAPACITY-1:0][KEY_W-1:0] cell_key;
  logic [CAPACITY-1:0]            cell_occ;
  cell_flags_t                    cell_flags [CAPACITY];
  logic [CAPACITY-1:0]            lt_vec;
  logic [CAPACITY-1:0]            le_vec;
  logic [CAPACITY-1:0]            eq_vec;
  logic [CAPACITY-1:0]            hit_vec;
  cell_upd_t                      upd;

  logic [CNT_W-1:0]           count;
  logic                       found;
  logic [KEY_W-1:0]           selected;

  logic [KEY_W-1:0]           res_key;
  logic [CNT_W-1:0]           res_cnt;
  logic [STAT_W-1:0]          res_status;

  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= s_tdata[2:0];
      req_key    <= s_tdata[34:3];
      req_rank   <= s_tdata[41:35];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= accept;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    l_le;
      logic                    l_occ;
      logic signed [KEY_W-1:0] l_key;
      logic                    r_occ;
      logic signed [KEY_W-1:0] r_key;

      if (i == 0) begin : g_head
        assign l_le  = 1'b1;
        assign l_occ = 1'b1;
        assign l_key = '0;
      end else begin : g_body
        assign l_le  = cell_flags[i-1].le;
        assign l_occ = cell_occ[i-1];
        assign l_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign r_occ = 1'b0;
        assign r_key = '0;
      end else begin : g_mid
        assign r_occ = cell_occ[i+1];
        assign r_key = cell_key[i+1];
      end

      osm_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .idx       (IDX_W'(i)),
        .cmp_en    (accept),
        .probe     (s_tdata[34:3]),
        .rank      (s_tdata[41:35]),
        .upd       (upd),
        .ins_key   (req_key),
        .left_le   (l_le),
        .left_occ  (l_occ),
        .left_key  (l_key),
        .right_occ (r_occ),
        .right_key (r_key),
        .key       (cell_key[i]),
        .occ       (cell_occ[i]),
        .flags     (cell_flags[i])
      );

      assign lt_vec[i]  = cell_flags[i].lt;
      assign le_vec[i]  = cell_flags[i].le;
      assign eq_vec[i]  = cell_flags[i].eq;
      assign hit_vec[i] = cell_flags[i].hit;
    end
  endgenerate

  osm_reduce u_reduce (
    .therm    ((req_action == ACT_COUNT_AT_MOST) ? le_vec : lt_vec),
    .eq_vec   (eq_vec),
    .hit_vec  (hit_vec),
    .keys     (cell_key),
    .count    (count),
    .found    (found),
    .selected (selected)
  );

  always_comb begin
    upd        = '0;
    fill_next  = fill;
    res_key    = '0;
    res_cnt    = fill;
    res_status = ST_OK;
    if (busy) begin
      unique case (req_action)
        ACT_SELECT: begin
          if (req_rank != '0 && 32'(req_rank) <= 32'(fill)) begin
            res_key = selected;
          end else begin
            res_status = ST_BAD_RANK;
          end
        end
        ACT_COUNT_LESS, ACT_COUNT_AT_MOST: begin
          res_cnt = count;
        end
        ACT_INSERT: begin
          if (32'(fill) >= 32'(CAPACITY)) begin
            res_status = ST_FULL;
          end else begin
            upd.ins   = 1'b1;
            fill_next = fill + CNT_W'(1);
            res_cnt   = fill_next;
          end
        end
        ACT_ERASE: begin
          if (found) begin
            upd.del   = 1'b1;
            fill_next = fill - CNT_W'(1);
            res_cnt   = fill_next;
          end else begin
            res_status = ST_ABSENT;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      m_tdata <= {(OUT_W - KEY_W - OUT_CNT_W - STAT_W)'(0), res_status,
                  OUT_CNT_W'(res_cnt), res_key};
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(CAPACITY))
    else $error("fill exceeds capacity");

  a_occ_matches_fill: assert property (@(posedge clk) disable iff (rst)
    32'($countones(cell_occ)) == 32'(fill))
    else $error("occupied cells disagree with fill");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !s_tready))
    else $error("request taken while one is in flight");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    busy |=> m_tvalid)
    else $error("result not presented after update pass");
`endif

endmodule

// ===== src/osm_cell.sv =====
// One storage cell of the sorted key chain: holds a key and its occupied bit.
// Depends on osm_pkg; instantiated in a row by order_statistic_multiset_core.
module osm_cell
  import osm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [IDX_W-1:0]         idx,
  input  logic                     cmp_en,
  input  logic signed [KEY_W-1:0]  probe,
  input  logic [RANK_W-1:0]        rank,
  input  cell_upd_t                upd,
  input  logic signed [KEY_W-1:0]  ins_key,
  input  logic                     left_le,
  input  logic                     left_occ,
  input  logic signed [KEY_W-1:0]  left_key,
  input  logic                     right_occ,
  input  logic signed [KEY_W-1:0]  right_key,
  output logic signed [KEY_W-1:0]  key,
  output logic                     occ,
  output cell_flags_t              flags
);

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      flags.lt  <= occ && (key < probe);
      flags.le  <= occ && (key <= probe);
      flags.eq  <= occ && (key == probe);
      flags.hit <= (32'(idx) + 32'd1) == 32'(rank);
    end
  end

  always_ff @(posedge clk) begin
    if (upd.ins && !flags.le) begin
      key <= left_le ? ins_key : left_key;
    end else if (upd.del && !flags.lt) begin
      key <= right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (upd.ins) begin
      occ <= occ || left_occ;
    end else if (upd.del && !flags.lt) begin
      occ <= right_occ;
    end
  end

endmodule

// ===== src/osm_reduce.sv =====
// Reduces the per-cell flags into a count, a presence bit and a selected key.
// Depends on osm_pkg; used by order_statistic_multiset_core.
module osm_reduce
  import osm_pkg::*;
(
  input  logic [CAPACITY-1:0]            therm,
  input  logic [CAPACITY-1:0]            eq_vec,
  input  logic [CAPACITY-1:0]            hit_vec,
  input  logic [CAPACITY-1:0][KEY_W-1:0] keys,
  output logic [CNT_W-1:0]               count,
  output logic                           found,
  output logic [KEY_W-1:0]               selected
);

  always_comb begin
    logic nxt;
    count    = '0;
    found    = 1'b0;
    selected = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      nxt = (i == CAPACITY - 1) ? 1'b0 : therm[(i + 1) % CAPACITY];
      if (therm[i] && !nxt) begin
        count = count | CNT_W'(i + 1);
      end
      found    = found | eq_vec[i];
      selected = selected | (keys[i] & {KEY_W{hit_vec[i]}});
    end
  end

endmodule
